// ===== hw/rtl/hmis_pkg.sv =====
// Shared types and constants for the insertion sorter.
// Used by hmis_cell and by the top level; depends on nothing else.
`default_nettype none

package hmis_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming word in order
        logic shift;    // move every word one cell towards the head
    } cell_ctrl_t;

endpackage : hmis_pkg

`default_nettype wire

// ===== hw/rtl/hmis_cell.sv =====
// One cell of the sorting chain: holds a single word and its valid bit.
// Depends on hmis_pkg for the data and command types.
`default_nettype none

module hmis_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hmis_pkg::cell_ctrl_t   ctrl,
    input  wire hmis_pkg::data_t        new_value,
    input  wire hmis_pkg::data_t        prev_value,
    input  wire logic                   prev_valid,
    input  wire logic                   prev_greater,
    input  wire hmis_pkg::data_t        next_value,
    input  wire logic                   next_valid,
    output hmis_pkg::data_t             value,
    output logic                        valid,
    output logic                        greater
);

    hmis_pkg::data_t value_reg;
    hmis_pkg::data_t value_next;
    logic            valid_reg;
    logic            valid_next;

    // An empty cell counts as larger than any word; strict compare keeps equal
    // words in arrival order.
    assign greater = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && greater)
        begin
            if (prev_greater)
            begin
                // make room: take the neighbour's word
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule : hmis_cell

`default_nettype wire

// ===== hw/rtl/hybrid_merge_insertion_sorter.sv =====
// Top level of the block sorter: a chain of hmis_cell instances and the
// load/drain control. Depends on hmis_pkg and hmis_cell.
//
// Words of a block enter one per cycle while loading; each is placed in
// ascending signed order by the cell chain on arrival, so no sort pass
// follows. The word flagged last turns the block to draining: the chain then
// shifts towards its head and presents one sorted word per cycle, slowed only
// by out_stall. in_stall stays high while draining, and the next block
// starts the cycle after the final word is taken. Words beyond MAX_ITEMS
// are dropped and every word of that block leaves with overflowed set.
`default_nettype none

module hybrid_merge_insertion_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [31:0]    data_value,
    input  wire logic           last_item,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         sorted_value,
    output logic                last_out,
    output logic                overflowed
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic overflow_reg;
    logic overflow_next;

    hmis_pkg::cell_ctrl_t ctrl;
    hmis_pkg::data_t      new_value;
    hmis_pkg::data_t      cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] cell_valid;
    logic [MAX_ITEMS-1:0] cell_greater;

    logic in_accept;
    logic out_accept;
    logic full;

    assign new_value  = hmis_pkg::data_t'(data_value);
    assign full       = cell_valid[MAX_ITEMS-1];
    assign in_stall   = (state_reg == ST_DRAIN);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (state_reg == ST_DRAIN);
    assign out_accept = out_valid && !out_stall;

    // drop the word once the store is full
    assign ctrl.insert = in_accept && !full;
    assign ctrl.shift  = out_accept;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            hmis_pkg::data_t prev_value;
            logic            prev_valid;
            logic            prev_greater;
            hmis_pkg::data_t next_value;
            logic            next_valid;

            if (gi == 0)
            begin : g_head
                assign prev_value   = '0;
                assign prev_valid   = 1'b0;
                assign prev_greater = 1'b0;
            end
            else
            begin : g_body
                assign prev_value   = cell_value[gi-1];
                assign prev_valid   = cell_valid[gi-1];
                assign prev_greater = cell_greater[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            hmis_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .new_value    (new_value),
                .prev_value   (prev_value),
                .prev_valid   (prev_valid),
                .prev_greater (prev_greater),
                .next_value   (next_value),
                .next_valid   (next_valid),
                .value        (cell_value[gi]),
                .valid        (cell_valid[gi]),
                .greater      (cell_greater[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // final word taken: back to loading with a clean flag
                if (out_accept && last_out)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    assign sorted_value = 32'(cell_value[0]);
    assign last_out     = !cell_valid[1];
    assign overflowed   = overflow_reg;

`ifndef SYNTHESIS
    // while draining the head cell always holds a word
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty head cell");

    // occupied cells form an unbroken run from the head
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in the cell chain");

    // taking the final word empties the chain
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_out) |=> (cell_valid == '0))
        else $error("chain not empty after final word");

    // while loading, overflow can only be flagged on a full chain
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOAD) && overflow_reg) |-> full)
        else $error("overflow flagged without a full chain");
`endif

endmodule : hybrid_merge_insertion_sorter

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for hybrid_merge_insertion_sorter: blocks of signed words
// go in, and each block must come back in ascending order with the right last and overflow flags.
// Depends on hmis_pkg and the sorter RTL only.
`default_nettype none

module testbench;

    typedef hmis_pkg::data_t data_t;

    localparam int unsigned MAX_ITEMS = 64;
    localparam data_t DATA_MIN = {1'b1, {31{1'b0}}};
    localparam data_t DATA_MAX = {1'b0, {31{1'b1}}};

    typedef struct packed {
        data_t value;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    class sort_scoreboard;
        int unsigned  capacity;
        data_t        block_words[$];
        bit           block_overflow;
        sorted_word_t sorted_words[$];
        int           mismatches;
        int           words_in;
        int           results_checked;
        int           blocks_sorted;
        int           overflow_blocks;

        function new(int unsigned cap);
            capacity = cap;
            block_overflow = 1'b0;
            mismatches = 0;
            words_in = 0;
            results_checked = 0;
            blocks_sorted = 0;
            overflow_blocks = 0;
        endfunction

        // Store the word (or drop it once full); on the last word, sort the block
        // and queue its results.
        function void note_word(data_t value, logic last);
            sorted_word_t w;
            data_t        key;
            int           i;
            int           j;
            words_in++;
            if (block_words.size() < capacity)
                block_words.push_back(value);
            else
                block_overflow = 1'b1;
            if (!last)
                return;
            // stable insertion sort; equal words keep arrival order
            for (i = 1; i < block_words.size(); i++) begin
                key = block_words[i];
                j = i;
                while (j > 0 && key < block_words[j-1]) begin
                    block_words[j] = block_words[j-1];
                    j--;
                end
                block_words[j] = key;
            end
            for (i = 0; i < block_words.size(); i++) begin
                w.value = block_words[i];
                w.last  = (i == block_words.size() - 1);
                w.ovf   = block_overflow;
                sorted_words.push_back(w);
            end
            blocks_sorted++;
            if (block_overflow)
                overflow_blocks++;
            block_words.delete();
            block_overflow = 1'b0;
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(data_t value, logic last, logic ovf);
            sorted_word_t w;
            if (sorted_words.size() == 0) begin
                report($sformatf("unexpected result word %0d", value));
                return;
            end
            w = sorted_words.pop_front();
            results_checked++;
            if (value !== w.value)
                report($sformatf("sorted_value %0d, wanted %0d", value, w.value));
            if (last !== w.last)
                report($sformatf("last_out %b, wanted %b (value %0d)", last, w.last, w.value));
            if (ovf !== w.ovf)
                report($sformatf("overflowed %b, wanted %b (value %0d)", ovf, w.ovf, w.value));
        endtask
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] data_value = '0;
    logic        last_item = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflowed;

    sort_scoreboard sb = new(MAX_ITEMS);

    int burst_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;

    hybrid_merge_insertion_sorter #(
        .MAX_ITEMS(MAX_ITEMS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_value(data_value),
        .last_item(last_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .last_out(last_out),
        .overflowed(overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: pick a new stall pattern whenever the stall timer runs out.
    always @(posedge clk)
    begin
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 4);
            stall_timer = 64;
        end
        stall_timer--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            3:       out_stall <= stall_timer[0];
            default: out_stall <= (stall_timer[3:0] > 11);
        endcase
    end

    // Inputs before outputs, so a word's results are always queued first.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_word(data_value, last_item);
            if (out_valid && !out_stall)
                sb.check_result(sorted_value, last_out, overflowed);
        end
    end

    function automatic data_t random_word();
        case ($urandom_range(0, 9))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2, 3, 4: return data_t'($signed($urandom_range(0, 8)) - 4);
            default: return data_t'($urandom);
        endcase
    endfunction

    // Hold the word until taken; open a new burst, after a random gap, when one runs out.
    task send_word(data_t value, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid   <= 1'b1;
        data_value <= value;
        last_item  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task send_block(int unsigned words);
        int unsigned k;
        for (k = 1; k <= words; k++)
            send_word(random_word(), k == words);
    endtask

    // Drop valid and hold off until every queued result has been taken.
    task wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.sorted_words.size() != 0);
    endtask

    initial
    begin
        int random_words;
        int size;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-word blocks at both extremes
        send_word(DATA_MIN, 1'b1);
        send_word(DATA_MAX, 1'b1);
        // extremes, zero, minus one and duplicates in one block
        send_word(5, 1'b0);
        send_word(DATA_MAX, 1'b0);
        send_word(DATA_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(5, 1'b0);
        send_word(DATA_MIN, 1'b0);
        send_word(1, 1'b1);
        // descending pair
        send_word(DATA_MAX, 1'b0);
        send_word(DATA_MIN, 1'b1);
        wait_drained();

        // exactly full, then one to three words over capacity so that those last words are dropped
        send_block(MAX_ITEMS);
        send_block(MAX_ITEMS + $urandom_range(1, 3));

        random_words = 0;
        while (random_words < 12) begin
            size = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            send_block(size);
            random_words += size;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d blocks sorted (%0d words, %0d over capacity), %0d results checked",
                 sb.blocks_sorted, sb.words_in, sb.overflow_blocks, sb.results_checked);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", sb.sorted_words.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/hmis_pkg.sv
hw/rtl/hmis_cell.sv
hw/rtl/hybrid_merge_insertion_sorter.sv
sim/testbench.sv
